// File: hdl/ssbpm_pkg.sv
`default_nettype none
package ssbpm_pkg;

  // Payload and configuration widths fixed by the port definitions.
  localparam int SAMPLE_W   = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int OSC_W      = 24;
  localparam int COEF_W     = 18;
  localparam int GAIN_W     = 28;
  localparam int OPA_W      = 28;
  localparam int OPB_W      = 24;
  localparam int PROD_W     = OPA_W + OPB_W;
  localparam int ACC_W      = 56;

  localparam int DEF_LOWPASS_TAPS = 83;
  localparam int DEF_BAND_TAPS    = 89;
  localparam int DEF_DECIMATION   = 4;

  localparam int DC_ALPHA      = 130941;
  localparam int OSC_ONE       = 4194304;
  localparam int OSC_GAIN_BASE = 8178893;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SIDEBAND = 2'd0,
    REG_NCO_EN   = 2'd1,
    REG_NCO_COS  = 2'd2,
    REG_NCO_SIN  = 2'd3
  } reg_idx_t;

  localparam int LP_ROM_LEN = 83;
  localparam int LP_ROM_AW  = $clog2(LP_ROM_LEN);
  localparam int BD_ROM_LEN = 89;
  localparam int BD_ROM_AW  = $clog2(BD_ROM_LEN);

  localparam int LP_COEF [LP_ROM_LEN] = '{
    -2, -5, -7, -5, 4, 20, 38, 48, 38, 0, -62, -129, -169, -149, -50, 118,
    307, 438, 430, 232, -138, -583, -937, -1020, -706, 0, 930, 1773, 2157,
    1784, 566, -1279, -3223, -4529, -4449, -2459, 1541, 7121, 13373, 19103,
    23127, 24574, 23127, 19103, 13373, 7121, 1541, -2459, -4449, -4529, -3223,
    -1279, 566, 1784, 2157, 1773, 930, 0, -706, -1020, -937, -583, -138, 232,
    430, 438, 307, 118, -50, -149, -169, -129, -62, 0, 38, 48, 38, 20, 4, -5,
    -7, -5, -2
  };

  localparam int BP_COEF [BD_ROM_LEN] = '{
    -27, -47, -7, -13, -108, -97, 12, -82, -256, -112, 37, -266, -435, -36, 0,
    -610, -549, 146, -223, -1087, -449, 364, -770, -1548, 0, 421, -1720, -1713,
    843, 0, -3021, -1184, 1976, -1334, -4462, 620, 3146, -4410, -5715, 5342,
    4032, -13752, -6446, 40155, 69794, 40155, -6446, -13752, 4032, 5342, -5715,
    -4410, 3146, 620, -4462, -1334, 1976, -1184, -3021, 0, 843, -1713, -1720,
    421, 0, -1548, -770, 364, -449, -1087, -223, 146, -549, -610, 0, -36, -435,
    -266, 37, -112, -256, -82, 12, -97, -108, -13, -7, -47, -27
  };

  localparam int HB_COEF [BD_ROM_LEN] = '{
    9, -29, -43, 15, 0, -114, -78, 50, -83, -269, -74, 64, -316, -464, 0, -48,
    -756, -609, 114, -450, -1382, -594, 122, -1323, -2069, -360, -273, -2798,
    -2596, 0, -1540, -4936, -2721, 105, -4465, -7881, -2287, -1059, -11224,
    -12905, -1311, -8433, -40728, -47046, 0, 47046, 40728, 8433, 1311, 12905,
    11224, 1059, 2287, 7881, 4465, -105, 2721, 4936, 1540, 0, 2596, 2798, 273,
    360, 2069, 1323, -122, 594, 1382, 450, -114, 609, 756, 48, 0, 464, 316,
    -64, 74, 269, 83, -50, 78, 114, 0, -15, 43, 29, -9
  };

  // Taps beyond the stored tables read as zero.
  function automatic logic signed [COEF_W-1:0] lp_coef(input logic [7:0] idx);
    if (idx < 8'(LP_ROM_LEN)) return COEF_W'(LP_COEF[idx[LP_ROM_AW-1:0]]);
    else return '0;
  endfunction

  function automatic logic signed [COEF_W-1:0] bp_coef(input logic [7:0] idx);
    if (idx < 8'(BD_ROM_LEN)) return COEF_W'(BP_COEF[idx[BD_ROM_AW-1:0]]);
    else return '0;
  endfunction

  function automatic logic signed [COEF_W-1:0] hb_coef(input logic [7:0] idx);
    if (idx < 8'(BD_ROM_LEN)) return COEF_W'(HB_COEF[idx[BD_ROM_AW-1:0]]);
    else return '0;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(32767)) return 16'sh7fff;
    else if (v < -ACC_W'(32768)) return 16'sh8000;
    else return v[15:0];
  endfunction

  function automatic logic signed [23:0] sat24(input logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(8388607)) return 24'sh7fffff;
    else if (v < -ACC_W'(8388608)) return 24'sh800000;
    else return v[23:0];
  endfunction

  // Round half up, then arithmetic shift right by s.
  function automatic logic signed [ACC_W-1:0] rnd_sh(input logic signed [ACC_W-1:0] v,
                                                     input int s);
    logic signed [ACC_W-1:0] half;
    half = ACC_W'(1) <<< (s - 1);
    return (v + half) >>> s;
  endfunction

endpackage
`default_nettype wire

// File: hdl/ssbpm_if.sv
`default_nettype none
interface ssbpm_in_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ssbpm_pkg::SAMPLE_W-1:0]      audio_in;
  modport source (output valid, output audio_in, input ready);
  modport sink   (input valid, input audio_in, output ready);
endinterface

interface ssbpm_out_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [ssbpm_pkg::SAMPLE_W-1:0]      out_i;
  logic signed [ssbpm_pkg::SAMPLE_W-1:0]      out_q;
  modport source (output valid, output out_i, output out_q, input ready);
  modport sink   (input valid, input out_i, input out_q, output ready);
endinterface

interface ssbpm_cfg_if;
  logic                                       valid;
  logic                                       ready;
  logic [ssbpm_pkg::CFG_IDX_W-1:0]            index;
  logic [ssbpm_pkg::CFG_DATA_W-1:0]           data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: hdl/ssb_phasing_modulator.sv
`default_nettype none
// Every accepted sample gives one I/Q beat. The band-pass and Hilbert filters run only on
// every DECIMATION-th sample, and the oscillator jobs only with the oscillator on; each
// filter issues its tap count of products on the one shared MAC. A new sample is taken
// only once the last one has been handed to the output register; a finished beat waits in
// the output register while the next sample is taken. Reset is synchronous and active high.
module ssb_phasing_modulator #(
  parameter int LOWPASS_TAPS = ssbpm_pkg::DEF_LOWPASS_TAPS,
  parameter int BAND_TAPS    = ssbpm_pkg::DEF_BAND_TAPS,
  parameter int DECIMATION   = ssbpm_pkg::DEF_DECIMATION
) (
  input  wire                 clk,
  input  wire                 rst,
  ssbpm_in_if.sink            in_ch,
  ssbpm_out_if.source         out_ch,
  ssbpm_cfg_if.sink           cfg_ch
);

  localparam int ACC_W  = ssbpm_pkg::ACC_W;
  localparam int OPA_W  = ssbpm_pkg::OPA_W;
  localparam int OPB_W  = ssbpm_pkg::OPB_W;
  localparam int PROD_W = ssbpm_pkg::PROD_W;
  localparam int MAXN   = (LOWPASS_TAPS > BAND_TAPS) ? LOWPASS_TAPS : BAND_TAPS;
  localparam int CNT_W  = $clog2(MAXN + 1);
  localparam int LP_AW  = (LOWPASS_TAPS > 1) ? $clog2(LOWPASS_TAPS) : 1;
  localparam int BD_AW  = (BAND_TAPS > 1) ? $clog2(BAND_TAPS) : 1;
  localparam int AW     = (LP_AW > BD_AW) ? LP_AW : BD_AW;
  localparam int PH_W   = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  // The sequencer walks through jobs; each job issues one or more products into the
  // shared multiply-accumulate pipe, waits for it to drain and then uses the sum.
  typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_WAIT, S_DONE} state_t;
  typedef enum logic [3:0] {
    JOB_DC, JOB_LP, JOB_BP, JOB_HB, JOB_II, JOB_IQ,
    JOB_ORE, JOB_OIM, JOB_MAG, JOB_NRE, JOB_NIM, JOB_XI, JOB_XQ
  } job_t;

  state_t state;
  job_t   job;
  logic [CNT_W-1:0] k;
  logic [AW-1:0]    rd_addr;

  // Configuration registers.
  logic signed [1:0]  sideband_sign;
  logic               nco_enable;
  logic signed [23:0] nco_cos;
  logic signed [23:0] nco_sin;

  // Filter and oscillator state.
  logic signed [15:0] x_reg;
  logic signed [15:0] dc_last_in;
  logic signed [23:0] dc_last_out;
  logic signed [15:0] held_i, held_q, dre, dim, fin_i, fin_q;
  logic signed [23:0] ore, oim, osc_re, osc_im;
  logic signed [ssbpm_pkg::GAIN_W-1:0] gain;
  logic [PH_W-1:0]    phase;

  // Delay lines are circular buffers; a fill count makes unwritten entries read as zero.
  logic [LP_AW-1:0] a_wp, i_wp;
  logic [BD_AW-1:0] b_wp;
  logic [CNT_W-1:0] a_cnt, b_cnt, i_cnt;

  logic signed [15:0] audio_mem [LOWPASS_TAPS];
  logic signed [15:0] band_mem  [BAND_TAPS];
  logic        [31:0] int_mem   [LOWPASS_TAPS];
  logic signed [15:0] audio_q, band_q;
  logic        [31:0] int_q;

  // MAC pipe: issue stage, product stage, accumulator.
  logic               iss_v, iss_alt, iss_zero, iss_clr, iss_sub;
  job_t               iss_job;
  logic [CNT_W-1:0]   iss_k;
  logic               mul_v, mul_clr, mul_sub;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic out_v;
  logic signed [15:0] out_i_r, out_q_r;

  // Issue decode.
  logic [CNT_W-1:0] job_len;
  logic [CNT_W-1:0] job_depth;
  logic             is_zero, is_sub, is_last;
  logic [AW-1:0]    rd_inc;

  always_comb begin
    job_len   = CNT_W'(1);
    job_depth = CNT_W'(LOWPASS_TAPS);
    is_zero   = 1'b0;
    unique case (job)
      JOB_LP: begin
        job_len = CNT_W'(LOWPASS_TAPS);
        is_zero = k < (CNT_W'(LOWPASS_TAPS) - a_cnt);
      end
      JOB_BP, JOB_HB: begin
        job_len   = CNT_W'(BAND_TAPS);
        job_depth = CNT_W'(BAND_TAPS);
        is_zero   = k < (CNT_W'(BAND_TAPS) - b_cnt);
      end
      JOB_II, JOB_IQ: begin
        job_len = CNT_W'(LOWPASS_TAPS);
        is_zero = k < (CNT_W'(LOWPASS_TAPS) - i_cnt);
      end
      JOB_ORE, JOB_OIM, JOB_MAG, JOB_XI, JOB_XQ: job_len = CNT_W'(2);
      default: job_len = CNT_W'(1);
    endcase
    is_sub  = k[0] && (job == JOB_ORE || job == JOB_XI);
    is_last = (k == job_len - CNT_W'(1));
    rd_inc  = (rd_addr == AW'(job_depth - CNT_W'(1))) ? '0 : rd_addr + AW'(1);
  end

  // Results of a drained job.
  logic signed [ACC_W-1:0] dc_y;
  logic signed [23:0]      dc_new;
  logic signed [15:0]      fir_res, out_res;
  logic signed [23:0]      osc_res;
  logic [PH_W-1:0]         phase_next;
  logic                    drained;
  logic                    a_we, b_we, i_we, new_band;
  logic signed [15:0]      a_wd, q_raw, q_scaled;
  logic [LP_AW-1:0]        a_wp_inc, i_wp_inc;
  logic [BD_AW-1:0]        b_wp_inc;
  logic signed [ACC_W-1:0] x_ext, in_ext;
  logic signed [17:0]      sign_ext, q_ext;

  always_comb begin
    x_ext    = ACC_W'(x_reg);
    in_ext   = ACC_W'(dc_last_in);
    dc_y     = ((x_ext - in_ext) <<< 7) + ssbpm_pkg::rnd_sh(acc, 17);
    dc_new   = ssbpm_pkg::sat24(dc_y);
    fir_res  = ssbpm_pkg::sat16(ssbpm_pkg::rnd_sh(acc, 17));
    osc_res  = ssbpm_pkg::sat24(ssbpm_pkg::rnd_sh(acc, 22));
    out_res  = ssbpm_pkg::sat16(ssbpm_pkg::rnd_sh(acc, 22));
    phase_next = (phase == PH_W'(DECIMATION - 1)) ? '0 : phase + PH_W'(1);
    drained  = (state == S_WAIT) && !iss_v && !mul_v;
    new_band = (phase_next == '0);
    a_we     = drained && (job == JOB_DC);
    a_wd     = ssbpm_pkg::sat16(ssbpm_pkg::rnd_sh(ACC_W'(dc_new), 7));
    b_we     = drained && (job == JOB_LP) && new_band;
    i_we     = drained && (((job == JOB_LP) && !new_band) || (job == JOB_HB));
    q_raw    = (job == JOB_HB) ? fir_res : held_q;
    sign_ext = 18'(sideband_sign);
    q_ext    = 18'(q_raw);
    q_scaled = ssbpm_pkg::sat16(ACC_W'(sign_ext * q_ext));
    a_wp_inc = (a_wp == LP_AW'(LOWPASS_TAPS - 1)) ? '0 : a_wp + LP_AW'(1);
    i_wp_inc = (i_wp == LP_AW'(LOWPASS_TAPS - 1)) ? '0 : i_wp + LP_AW'(1);
    b_wp_inc = (b_wp == BD_AW'(BAND_TAPS - 1)) ? '0 : b_wp + BD_AW'(1);
  end

  // Delay line memories with registered read data.
  always_ff @(posedge clk) begin
    if (a_we) audio_mem[a_wp] <= a_wd;
    if (state == S_ISSUE && job == JOB_LP) audio_q <= audio_mem[rd_addr[LP_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (b_we) band_mem[b_wp] <= fir_res;
    if (state == S_ISSUE && (job == JOB_BP || job == JOB_HB)) begin
      band_q <= band_mem[rd_addr[BD_AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (i_we) int_mem[i_wp] <= {held_i, q_scaled};
    if (state == S_ISSUE && (job == JOB_II || job == JOB_IQ)) begin
      int_q <= int_mem[rd_addr[LP_AW-1:0]];
    end
  end

  // Operand selection for the shared multiplier.
  logic signed [OPA_W-1:0] op_a;
  logic signed [OPB_W-1:0] op_b;
  logic [7:0]              cidx;

  always_comb begin
    cidx = 8'(iss_k);
    op_a = '0;
    op_b = '0;
    unique case (iss_job)
      JOB_DC: begin
        op_a = OPA_W'(dc_last_out);
        op_b = OPB_W'(ssbpm_pkg::DC_ALPHA);
      end
      JOB_LP: begin
        op_a = OPA_W'(audio_q);
        op_b = OPB_W'(ssbpm_pkg::lp_coef(cidx));
      end
      JOB_BP: begin
        op_a = OPA_W'(band_q);
        op_b = OPB_W'(ssbpm_pkg::bp_coef(cidx));
      end
      JOB_HB: begin
        op_a = OPA_W'(band_q);
        op_b = OPB_W'(ssbpm_pkg::hb_coef(cidx));
      end
      JOB_II: begin
        op_a = OPA_W'($signed(int_q[31:16]));
        op_b = OPB_W'(ssbpm_pkg::lp_coef(cidx));
      end
      JOB_IQ: begin
        op_a = OPA_W'($signed(int_q[15:0]));
        op_b = OPB_W'(ssbpm_pkg::lp_coef(cidx));
      end
      JOB_ORE: begin
        op_a = iss_alt ? OPA_W'(osc_im) : OPA_W'(osc_re);
        op_b = iss_alt ? nco_sin : nco_cos;
      end
      JOB_OIM: begin
        op_a = iss_alt ? OPA_W'(osc_re) : OPA_W'(osc_im);
        op_b = iss_alt ? nco_sin : nco_cos;
      end
      JOB_MAG: begin
        op_a = iss_alt ? OPA_W'(osc_im) : OPA_W'(osc_re);
        op_b = iss_alt ? osc_im : osc_re;
      end
      JOB_NRE: begin
        op_a = gain;
        op_b = ore;
      end
      JOB_NIM: begin
        op_a = gain;
        op_b = oim;
      end
      JOB_XI: begin
        op_a = iss_alt ? OPA_W'(dim) : OPA_W'(dre);
        op_b = iss_alt ? oim : ore;
      end
      JOB_XQ: begin
        op_a = iss_alt ? OPA_W'(dim) : OPA_W'(dre);
        op_b = iss_alt ? ore : oim;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    if (iss_zero) op_a = '0;
  end

  logic signed [ACC_W-1:0] prod_ext, acc_base;

  always_comb begin
    prod_ext = ACC_W'(prod);
    acc_base = mul_clr ? '0 : acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iss_v <= 1'b0;
      mul_v <= 1'b0;
    end else begin
      iss_v <= (state == S_ISSUE);
      mul_v <= iss_v;
    end
    iss_job  <= job;
    iss_k    <= k;
    iss_alt  <= k[0];
    iss_zero <= is_zero;
    iss_clr  <= (k == '0);
    iss_sub  <= is_sub;
    prod     <= op_a * op_b;
    mul_clr  <= iss_clr;
    mul_sub  <= iss_sub;
    if (mul_v) acc <= mul_sub ? acc_base - prod_ext : acc_base + prod_ext;
  end

  // Sequencer, state registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      job           <= JOB_DC;
      k             <= '0;
      rd_addr       <= '0;
      sideband_sign <= 2'sd1;
      nco_enable    <= 1'b0;
      nco_cos       <= 24'(ssbpm_pkg::OSC_ONE);
      nco_sin       <= '0;
      dc_last_in    <= '0;
      dc_last_out   <= '0;
      held_i        <= '0;
      held_q        <= '0;
      phase         <= PH_W'(DECIMATION - 1);
      osc_re        <= 24'(ssbpm_pkg::OSC_ONE);
      osc_im        <= '0;
      a_wp          <= '0;
      b_wp          <= '0;
      i_wp          <= '0;
      a_cnt         <= '0;
      b_cnt         <= '0;
      i_cnt         <= '0;
      out_v         <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          ssbpm_pkg::REG_SIDEBAND: sideband_sign <= cfg_ch.data[1:0];
          ssbpm_pkg::REG_NCO_EN:   nco_enable    <= cfg_ch.data[0];
          ssbpm_pkg::REG_NCO_COS:  nco_cos       <= cfg_ch.data;
          ssbpm_pkg::REG_NCO_SIN:  nco_sin       <= cfg_ch.data;
          default: ;
        endcase
      end

      // In S_DONE the output register is handled below.
      if (out_v && out_ch.ready && state != S_DONE) out_v <= 1'b0;

      if (a_we) begin
        a_wp  <= a_wp_inc;
        if (a_cnt != CNT_W'(LOWPASS_TAPS)) a_cnt <= a_cnt + CNT_W'(1);
      end
      if (b_we) begin
        b_wp  <= b_wp_inc;
        if (b_cnt != CNT_W'(BAND_TAPS)) b_cnt <= b_cnt + CNT_W'(1);
      end
      if (i_we) begin
        i_wp  <= i_wp_inc;
        if (i_cnt != CNT_W'(LOWPASS_TAPS)) i_cnt <= i_cnt + CNT_W'(1);
      end

      unique case (state)
        S_IDLE: begin
          if (in_ch.valid) begin
            x_reg <= in_ch.audio_in;
            job   <= JOB_DC;
            k     <= '0;
            state <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          rd_addr <= rd_inc;
          if (is_last) begin
            k     <= '0;
            state <= S_WAIT;
          end else begin
            k <= k + CNT_W'(1);
          end
        end
        S_WAIT: begin
          if (drained) begin
            state <= S_ISSUE;
            unique case (job)
              JOB_DC: begin
                dc_last_out <= dc_new;
                dc_last_in  <= x_reg;
                rd_addr     <= AW'(a_wp_inc);
                job         <= JOB_LP;
              end
              JOB_LP: begin
                phase <= phase_next;
                if (new_band) begin
                  rd_addr <= AW'(b_wp_inc);
                  job     <= JOB_BP;
                end else begin
                  rd_addr <= AW'(i_wp_inc);
                  job     <= JOB_II;
                end
              end
              JOB_BP: begin
                held_i  <= fir_res;
                rd_addr <= AW'(b_wp);
                job     <= JOB_HB;
              end
              JOB_HB: begin
                held_q  <= fir_res;
                rd_addr <= AW'(i_wp_inc);
                job     <= JOB_II;
              end
              JOB_II: begin
                dre     <= fir_res;
                rd_addr <= AW'(i_wp);
                job     <= JOB_IQ;
              end
              JOB_IQ: begin
                dim <= fir_res;
                if (nco_enable) begin
                  job <= JOB_ORE;
                end else begin
                  fin_i <= dre;
                  fin_q <= fir_res;
                  state <= S_DONE;
                end
              end
              JOB_ORE: begin
                ore <= osc_res;
                job <= JOB_OIM;
              end
              JOB_OIM: begin
                oim <= osc_res;
                job <= JOB_MAG;
              end
              JOB_MAG: begin
                gain <= ssbpm_pkg::GAIN_W'(ACC_W'(ssbpm_pkg::OSC_GAIN_BASE)
                        - ssbpm_pkg::rnd_sh(acc, 22));
                job  <= JOB_NRE;
              end
              JOB_NRE: begin
                osc_re <= osc_res;
                job    <= JOB_NIM;
              end
              JOB_NIM: begin
                osc_im <= osc_res;
                job    <= JOB_XI;
              end
              JOB_XI: begin
                fin_i <= out_res;
                job   <= JOB_XQ;
              end
              JOB_XQ: begin
                fin_q <= out_res;
                state <= S_DONE;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DONE: begin
          // Hand the pair to the output register once it is free.
          if (!out_v || out_ch.ready) begin
            out_v   <= 1'b1;
            out_i_r <= fin_i;
            out_q_r <= fin_q;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready  = (state == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_v;
  assign out_ch.out_i = out_i_r;
  assign out_ch.out_q = out_q_r;

endmodule
`default_nettype wire
